FILE: rtl/core/sbpt_pkg.sv
// ----------------------------------------------------------------------------
// sbpt_pkg
// Shared constants for the shadow bitmap poison tracker: defaults, port
// widths, operation codes and the depth of the job queue.
// ----------------------------------------------------------------------------
package sbpt_pkg;

    // defaults for the top-level parameters
    localparam int REGIONS_DEF          = 2;
    localparam int GRANULE_BYTES_DEF    = 4;
    localparam int WORD_BITS_DEF        = 32;
    localparam int REGION_MAX_BYTES_DEF = 65536;

    // fixed field widths
    localparam int OP_W   = 2;
    localparam int ADDR_W = 32;
    localparam int LEN_W  = 17;
    localparam int SIZE_W = 17;
    localparam int DATA_W = 32;

    // operation codes
    localparam logic [OP_W-1:0] OP_POISON   = 2'd0;
    localparam logic [OP_W-1:0] OP_UNPOISON = 2'd1;
    localparam logic [OP_W-1:0] OP_CHECK    = 2'd2;

    // jobs held between classifier and walker
    localparam int QUEUE_DEPTH = 2;

endpackage

FILE: rtl/core/shadow_bitmap_poison_tracker_unit.sv
// ----------------------------------------------------------------------------
// shadow_bitmap_poison_tracker_unit
// Shadow bitmap poison tracker: poison, unpoison and check of byte ranges
// against per-region shadow bitmaps of one bit per granule.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. For an address inside
// a region the front end then runs the region match, four constant divisions
// through one shared multiplier and the hand-over of the job, and drops busy,
// so a new command can be taken while the walker still works on earlier ones.
// An address outside every region skips the divisions. The hand-over waits
// for as long as the job queue is full.
// The walker touches one shadow word per cycle: a job costs the words its
// granule range spans plus the load, read latency drain and result steps,
// and the sustained rate is the slower of the two sides. Each result shows for
// exactly one cycle with done high and cannot be held off. After reset the
// whole shadow is swept to all ones, one word per cycle; writing a size
// register sweeps that region's words the same way. cfg_ready is high only
// with the whole block idle, so configuration transfers wait until every
// result has gone out.
// ----------------------------------------------------------------------------
module shadow_bitmap_poison_tracker_unit #(
    parameter int REGIONS          = sbpt_pkg::REGIONS_DEF,
    parameter int GRANULE_BYTES    = sbpt_pkg::GRANULE_BYTES_DEF,
    parameter int WORD_BITS        = sbpt_pkg::WORD_BITS_DEF,
    parameter int REGION_MAX_BYTES = sbpt_pkg::REGION_MAX_BYTES_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // command side
    input  logic                                 start,
    output logic                                 busy,
    input  logic [sbpt_pkg::OP_W-1:0]            operation,
    input  logic [sbpt_pkg::ADDR_W-1:0]          address,
    input  logic [sbpt_pkg::LEN_W-1:0]           length,
    // result side
    output logic                                 done,
    output logic                                 poisoned,
    output logic                                 in_region,
    output logic                                 region_hit,
    output logic                                 overrun,
    // configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [$clog2(2 * REGIONS)-1:0]       cfg_index,
    input  logic [sbpt_pkg::DATA_W-1:0]          cfg_data
);

    localparam int MAX_GRANULES = (REGION_MAX_BYTES + GRANULE_BYTES - 1) / GRANULE_BYTES;
    localparam int WPR          = (MAX_GRANULES + WORD_BITS - 1) / WORD_BITS;
    localparam int TOTAL        = REGIONS * WPR;
    localparam int GR_W         = $clog2(MAX_GRANULES + 1);
    localparam int MA_W         = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int BIT_W        = $clog2(WORD_BITS);
    localparam int REG_W        = (REGIONS > 1) ? $clog2(REGIONS) : 1;
    localparam int IDX_W        = $clog2(2 * REGIONS);

    // one classified job: what to do, where the walk starts, how far it goes
    typedef struct packed {
        logic               wr;          // poison or unpoison
        logic               set;         // poison
        logic               chk;         // check
        logic [MA_W-1:0]    addr;        // first shadow word
        logic [BIT_W-1:0]   bit_pos;     // first bit in that word
        logic [GR_W-1:0]    count;       // granules to cover
        logic               in_region;
        logic               region_hit;
        logic               overrun;
    } sbpt_job_t;

    // configuration registers: even index is a base, odd index a size
    logic [sbpt_pkg::ADDR_W-1:0] base_reg [REGIONS];
    logic [sbpt_pkg::SIZE_W-1:0] size_reg [REGIONS];

    logic                cfg_fire;
    logic [IDX_W-1:0]    cfg_region;
    logic                fill_req;
    logic [REG_W-1:0]    fill_region;

    sbpt_job_t           push_job;
    sbpt_job_t           head_job;
    logic                q_push;
    logic                q_pop;
    logic                q_full;
    logic                q_empty;
    logic                back_idle;

    assign cfg_ready   = back_idle && q_empty && !busy;
    assign cfg_fire    = cfg_valid && cfg_ready;
    assign cfg_region  = cfg_index >> 1;
    // a size write, zero included, re-poisons the whole region
    assign fill_req    = cfg_fire && cfg_index[0] && (32'(cfg_region) < 32'(REGIONS));
    assign fill_region = REG_W'(cfg_region);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < REGIONS; r++)
            begin
                base_reg[r] <= '0;
                size_reg[r] <= '0;
            end
        end
        else if (cfg_fire)
        begin
            for (int r = 0; r < REGIONS; r++)
            begin
                if (32'(cfg_region) == 32'(r))
                begin
                    if (cfg_index[0])
                    begin
                        size_reg[r] <= cfg_data[sbpt_pkg::SIZE_W-1:0];
                    end
                    else
                    begin
                        base_reg[r] <= cfg_data[sbpt_pkg::ADDR_W-1:0];
                    end
                end
            end
        end
    end

    sbpt_front #(
        .REGIONS          (REGIONS),
        .GRANULE_BYTES    (GRANULE_BYTES),
        .WORD_BITS        (WORD_BITS),
        .REGION_MAX_BYTES (REGION_MAX_BYTES),
        .job_t            (sbpt_job_t)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .operation (operation),
        .address   (address),
        .length    (length),
        .cfg_base  (base_reg),
        .cfg_size  (size_reg),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (push_job)
    );

    sbpt_queue #(
        .entry_t (sbpt_job_t)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_job),
        .pop        (q_pop),
        .head       (head_job),
        .full       (q_full),
        .empty      (q_empty)
    );

    sbpt_back #(
        .REGIONS          (REGIONS),
        .GRANULE_BYTES    (GRANULE_BYTES),
        .WORD_BITS        (WORD_BITS),
        .REGION_MAX_BYTES (REGION_MAX_BYTES),
        .job_t            (sbpt_job_t)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .fill_req    (fill_req),
        .fill_region (fill_region),
        .q_empty     (q_empty),
        .q_job       (head_job),
        .q_pop       (q_pop),
        .idle        (back_idle),
        .done        (done),
        .poisoned    (poisoned),
        .in_region   (in_region),
        .region_hit  (region_hit),
        .overrun     (overrun)
    );

endmodule

FILE: rtl/core/sbpt_queue.sv
// ----------------------------------------------------------------------------
// sbpt_queue
// Short FIFO of classified jobs between the front end and the shadow walker.
// ----------------------------------------------------------------------------
module sbpt_queue #(
    parameter type entry_t = logic
) (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    input  logic   pop,
    output entry_t head,
    output logic   full,
    output logic   empty
);

    localparam int DEPTH = sbpt_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t             slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push;
    logic               do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: rtl/core/sbpt_front.sv
// ----------------------------------------------------------------------------
// sbpt_front
// Takes a command, finds its region and turns the byte range into a job:
// first shadow word, first bit, granule count, plus the status flags.
// ----------------------------------------------------------------------------
module sbpt_front #(
    parameter int  REGIONS          = sbpt_pkg::REGIONS_DEF,
    parameter int  GRANULE_BYTES    = sbpt_pkg::GRANULE_BYTES_DEF,
    parameter int  WORD_BITS        = sbpt_pkg::WORD_BITS_DEF,
    parameter int  REGION_MAX_BYTES = sbpt_pkg::REGION_MAX_BYTES_DEF,
    parameter type job_t            = logic
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [sbpt_pkg::OP_W-1:0]   operation,
    input  logic [sbpt_pkg::ADDR_W-1:0] address,
    input  logic [sbpt_pkg::LEN_W-1:0]  length,
    input  logic [sbpt_pkg::ADDR_W-1:0] cfg_base [REGIONS],
    input  logic [sbpt_pkg::SIZE_W-1:0] cfg_size [REGIONS],
    input  logic                        q_full,
    output logic                        q_push,
    output job_t                        q_job
);

    localparam int MAX_GRANULES = (REGION_MAX_BYTES + GRANULE_BYTES - 1) / GRANULE_BYTES;
    localparam int WPR          = (MAX_GRANULES + WORD_BITS - 1) / WORD_BITS;
    localparam int TOTAL        = REGIONS * WPR;
    localparam int SZ_W         = $clog2(REGION_MAX_BYTES + 1);
    localparam int GR_W         = $clog2(MAX_GRANULES + 1);
    localparam int DIV_IN_W     = $clog2(REGION_MAX_BYTES + (1 << sbpt_pkg::LEN_W)
                                         + GRANULE_BYTES);
    localparam int MUL_W        = DIV_IN_W + 1;
    localparam int PROD_W       = DIV_IN_W + MUL_W;
    localparam int WW           = (WPR > 1) ? $clog2(WPR) : 1;
    localparam int MA_W         = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int BIT_W        = $clog2(WORD_BITS);
    localparam int REG_W        = (REGIONS > 1) ? $clog2(REGIONS) : 1;

    // reciprocals for division by a constant: q0 = (x * M) >> DIV_IN_W is q or q - 1
    localparam longint unsigned DIV_ONE = 64'd1 << DIV_IN_W;
    localparam logic [MUL_W-1:0] RECIP_G = MUL_W'(DIV_ONE / GRANULE_BYTES);
    localparam logic [MUL_W-1:0] RECIP_W = MUL_W'(DIV_ONE / WORD_BITS);

    typedef enum logic [2:0] {F_IDLE, F_MATCH, F_MUL, F_FIX, F_PUSH} state_t;
    typedef enum logic [1:0] {DIV_START, DIV_LIMIT, DIV_COUNT, DIV_WORD} div_sel_t;

    state_t                        state_reg;
    div_sel_t                      div_sel_reg;
    logic [sbpt_pkg::OP_W-1:0]     op_reg;
    logic [sbpt_pkg::ADDR_W-1:0]   addr_reg;
    logic [sbpt_pkg::LEN_W-1:0]    len_reg;
    logic                          hit_reg;
    logic [REG_W-1:0]              hidx_reg;
    logic [SZ_W-1:0]               off_reg;
    logic [SZ_W-1:0]               size_reg;
    logic [PROD_W-1:0]             mul_reg;
    logic [GR_W-1:0]               start_reg;
    logic [GR_W-1:0]               limit_reg;
    logic [DIV_IN_W-1:0]           nraw_reg;
    logic [WW-1:0]                 word_reg;
    logic [BIT_W-1:0]              bitpos_reg;

    logic                          match_any;
    logic [REG_W-1:0]              match_idx;
    logic [SZ_W-1:0]               match_off;
    logic [SZ_W-1:0]               match_size;

    logic                          long_check;
    logic                          by_word;
    logic [DIV_IN_W-1:0]           div_x;
    logic [DIV_IN_W-1:0]           div_d;
    logic [MUL_W-1:0]              div_m;
    logic [DIV_IN_W-1:0]           div_q0;
    logic [DIV_IN_W-1:0]           div_back;
    logic [DIV_IN_W-1:0]           div_rem;
    logic                          div_fix;
    logic [DIV_IN_W-1:0]           div_q;
    logic [DIV_IN_W-1:0]           div_r;

    logic [GR_W-1:0]               span;
    logic [DIV_IN_W-1:0]           n_sel;
    logic [GR_W-1:0]               n_clip;
    logic                          over;

    assign busy = (state_reg != F_IDLE);

    // region match; the lowest matching region wins
    always_comb
    begin
        logic [32:0]     diff;
        logic [SZ_W-1:0] eff;
        match_any  = 1'b0;
        match_idx  = '0;
        match_off  = '0;
        match_size = '0;
        for (int r = REGIONS - 1; r >= 0; r--)
        begin
            eff  = (32'(cfg_size[r]) > 32'(REGION_MAX_BYTES)) ? SZ_W'(REGION_MAX_BYTES)
                                                             : SZ_W'(cfg_size[r]);
            diff = {1'b0, addr_reg} - {1'b0, cfg_base[r]};
            if (!diff[32] && eff != '0 && diff[31:0] < 32'(eff))
            begin
                match_any  = 1'b1;
                match_idx  = REG_W'(r);
                match_off  = SZ_W'(diff[31:0]);
                match_size = eff;
            end
        end
    end

    // shared divide-by-constant step
    assign long_check = (op_reg == sbpt_pkg::OP_CHECK) &&
                        (32'(len_reg) > 32'(GRANULE_BYTES));
    assign by_word    = (div_sel_reg == DIV_WORD);
    assign div_d      = by_word ? DIV_IN_W'(WORD_BITS) : DIV_IN_W'(GRANULE_BYTES);
    assign div_m      = by_word ? RECIP_W : RECIP_G;

    always_comb
    begin
        case (div_sel_reg)
            DIV_START: div_x = DIV_IN_W'(off_reg);
            DIV_LIMIT: div_x = DIV_IN_W'(size_reg) + DIV_IN_W'(GRANULE_BYTES - 1);
            DIV_COUNT: div_x = DIV_IN_W'(len_reg)
                               + (long_check ? DIV_IN_W'(GRANULE_BYTES - 1) : '0);
            default:   div_x = DIV_IN_W'(start_reg);
        endcase
    end

    assign div_q0   = DIV_IN_W'(mul_reg >> DIV_IN_W);
    assign div_back = DIV_IN_W'(div_q0 * div_d);
    assign div_rem  = div_x - div_back;
    assign div_fix  = (div_rem >= div_d);
    assign div_q    = div_fix ? div_q0 + 1'b1 : div_q0;
    assign div_r    = div_fix ? div_rem - div_d : div_rem;

    // job assembly
    assign span = limit_reg - start_reg;
    assign over = (DIV_IN_W'(off_reg) + DIV_IN_W'(len_reg)) > DIV_IN_W'(size_reg);

    always_comb
    begin
        case (op_reg)
            sbpt_pkg::OP_POISON,
            sbpt_pkg::OP_UNPOISON: n_sel = nraw_reg;
            sbpt_pkg::OP_CHECK:    n_sel = long_check ? nraw_reg : DIV_IN_W'(1);
            default:               n_sel = '0;
        endcase
    end

    assign n_clip = (n_sel > DIV_IN_W'(span)) ? span : GR_W'(n_sel);
    assign q_push = (state_reg == F_PUSH) && !q_full;

    always_comb
    begin
        q_job = '0;
        if (hit_reg)
        begin
            q_job.wr         = (op_reg == sbpt_pkg::OP_POISON) ||
                               (op_reg == sbpt_pkg::OP_UNPOISON);
            q_job.set        = (op_reg == sbpt_pkg::OP_POISON);
            q_job.chk        = (op_reg == sbpt_pkg::OP_CHECK);
            q_job.addr       = MA_W'(hidx_reg) * MA_W'(WPR) + MA_W'(word_reg);
            q_job.bit_pos    = bitpos_reg;
            q_job.count      = n_clip;
            q_job.in_region  = 1'b1;
            q_job.region_hit = hidx_reg[0];
            q_job.overrun    = over;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= F_IDLE;
            div_sel_reg <= DIV_START;
            op_reg      <= '0;
            addr_reg    <= '0;
            len_reg     <= '0;
            hit_reg     <= 1'b0;
            hidx_reg    <= '0;
            off_reg     <= '0;
            size_reg    <= '0;
            mul_reg     <= '0;
            start_reg   <= '0;
            limit_reg   <= '0;
            nraw_reg    <= '0;
            word_reg    <= '0;
            bitpos_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (start)
                    begin
                        op_reg    <= operation;
                        addr_reg  <= address;
                        len_reg   <= length;
                        state_reg <= F_MATCH;
                    end
                end
                F_MATCH:
                begin
                    hit_reg     <= match_any;
                    hidx_reg    <= match_idx;
                    off_reg     <= match_off;
                    size_reg    <= match_size;
                    div_sel_reg <= DIV_START;
                    state_reg   <= match_any ? F_MUL : F_PUSH;
                end
                F_MUL:
                begin
                    mul_reg   <= PROD_W'(div_x) * PROD_W'(div_m);
                    state_reg <= F_FIX;
                end
                F_FIX:
                begin
                    case (div_sel_reg)
                        DIV_START: start_reg <= GR_W'(div_q);
                        DIV_LIMIT: limit_reg <= GR_W'(div_q);
                        DIV_COUNT: nraw_reg  <= div_q;
                        default:
                        begin
                            word_reg   <= WW'(div_q);
                            bitpos_reg <= BIT_W'(div_r);
                        end
                    endcase
                    if (div_sel_reg == DIV_WORD)
                    begin
                        state_reg <= F_PUSH;
                    end
                    else
                    begin
                        div_sel_reg <= div_sel_t'(div_sel_reg + 2'd1);
                        state_reg   <= F_MUL;
                    end
                end
                F_PUSH:
                begin
                    if (!q_full)
                    begin
                        state_reg <= F_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: rtl/core/sbpt_back.sv
// ----------------------------------------------------------------------------
// sbpt_back
// Owns the shadow memory. Walks a job one shadow word per cycle
// (read, then modify-write or test), and sweeps a region to all ones on fill.
// ----------------------------------------------------------------------------
module sbpt_back #(
    parameter int  REGIONS          = sbpt_pkg::REGIONS_DEF,
    parameter int  GRANULE_BYTES    = sbpt_pkg::GRANULE_BYTES_DEF,
    parameter int  WORD_BITS        = sbpt_pkg::WORD_BITS_DEF,
    parameter int  REGION_MAX_BYTES = sbpt_pkg::REGION_MAX_BYTES_DEF,
    parameter type job_t            = logic
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      fill_req,
    input  logic [((REGIONS > 1) ? $clog2(REGIONS) : 1)-1:0] fill_region,
    input  logic                                      q_empty,
    input  job_t                                      q_job,
    output logic                                      q_pop,
    output logic                                      idle,
    output logic                                      done,
    output logic                                      poisoned,
    output logic                                      in_region,
    output logic                                      region_hit,
    output logic                                      overrun
);

    localparam int MAX_GRANULES = (REGION_MAX_BYTES + GRANULE_BYTES - 1) / GRANULE_BYTES;
    localparam int WPR          = (MAX_GRANULES + WORD_BITS - 1) / WORD_BITS;
    localparam int TOTAL        = REGIONS * WPR;
    localparam int GR_W         = $clog2(MAX_GRANULES + 1);
    localparam int MA_W         = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int BIT_W        = $clog2(WORD_BITS);
    localparam int MASK_W       = WORD_BITS + 1;

    typedef enum logic [1:0] {B_FILL, B_IDLE, B_WALK} state_t;

    state_t                 state_reg;
    logic [MA_W-1:0]        fill_addr_reg;
    logic [MA_W-1:0]        fill_last_reg;
    logic [MA_W-1:0]        walk_addr_reg;
    logic [BIT_W-1:0]       bitpos_reg;
    logic [GR_W-1:0]        remain_reg;
    logic                   wr_reg;
    logic                   set_reg;
    logic                   chk_reg;
    logic                   in_region_reg;
    logic                   region_hit_reg;
    logic                   overrun_reg;
    logic                   acc_reg;
    logic                   s1_valid_reg;
    logic [MA_W-1:0]        s1_addr_reg;
    logic [WORD_BITS-1:0]   s1_mask_reg;
    logic                   done_reg;
    logic                   poisoned_reg;
    logic                   out_in_region_reg;
    logic                   out_region_hit_reg;
    logic                   out_overrun_reg;

    logic [WORD_BITS-1:0]   shadow_mem [TOTAL];
    logic [WORD_BITS-1:0]   rd_data_reg;

    logic                   issue;
    logic [BIT_W:0]         room;
    logic [GR_W-1:0]        take;
    logic [BIT_W:0]         hi;
    logic [MASK_W-1:0]      ones_hi;
    logic [MASK_W-1:0]      ones_lo;
    logic [WORD_BITS-1:0]   mask;
    logic                   mem_we;
    logic [MA_W-1:0]        mem_waddr;
    logic [WORD_BITS-1:0]   mem_wdata;
    logic [MA_W-1:0]        fill_first;

    assign idle  = (state_reg == B_IDLE);
    assign q_pop = idle && !fill_req && !q_empty;
    assign issue = (state_reg == B_WALK) && (remain_reg != '0);

    // bits of the current word covered by the remaining granules
    assign room    = (BIT_W + 1)'(WORD_BITS) - {1'b0, bitpos_reg};
    assign take    = (remain_reg < GR_W'(room)) ? remain_reg : GR_W'(room);
    assign hi      = {1'b0, bitpos_reg} + (BIT_W + 1)'(take);
    assign ones_hi = (MASK_W'(1) << hi) - MASK_W'(1);
    assign ones_lo = (MASK_W'(1) << bitpos_reg) - MASK_W'(1);
    assign mask    = WORD_BITS'(ones_hi & ~ones_lo);

    assign fill_first = MA_W'(fill_region) * MA_W'(WPR);

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = s1_addr_reg;
        mem_wdata = set_reg ? (rd_data_reg | s1_mask_reg) : (rd_data_reg & ~s1_mask_reg);
        if (state_reg == B_FILL)
        begin
            mem_we    = 1'b1;
            mem_waddr = fill_addr_reg;
            mem_wdata = '1;
        end
        else if (s1_valid_reg && wr_reg)
        begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            shadow_mem[mem_waddr] <= mem_wdata;
        end
        if (issue)
        begin
            rd_data_reg <= shadow_mem[walk_addr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= B_FILL;
            fill_addr_reg      <= '0;
            fill_last_reg      <= MA_W'(TOTAL - 1);
            walk_addr_reg      <= '0;
            bitpos_reg         <= '0;
            remain_reg         <= '0;
            wr_reg             <= 1'b0;
            set_reg            <= 1'b0;
            chk_reg            <= 1'b0;
            in_region_reg      <= 1'b0;
            region_hit_reg     <= 1'b0;
            overrun_reg        <= 1'b0;
            acc_reg            <= 1'b0;
            s1_valid_reg       <= 1'b0;
            s1_addr_reg        <= '0;
            s1_mask_reg        <= '0;
            done_reg           <= 1'b0;
            poisoned_reg       <= 1'b0;
            out_in_region_reg  <= 1'b0;
            out_region_hit_reg <= 1'b0;
            out_overrun_reg    <= 1'b0;
        end
        else
        begin
            done_reg     <= 1'b0;
            s1_valid_reg <= issue;
            if (s1_valid_reg && chk_reg && (|(rd_data_reg & s1_mask_reg)))
            begin
                acc_reg <= 1'b1;
            end
            case (state_reg)
                B_FILL:
                begin
                    if (fill_addr_reg == fill_last_reg)
                    begin
                        state_reg <= B_IDLE;
                    end
                    else
                    begin
                        fill_addr_reg <= fill_addr_reg + 1'b1;
                    end
                end
                B_IDLE:
                begin
                    if (fill_req)
                    begin
                        fill_addr_reg <= fill_first;
                        fill_last_reg <= fill_first + MA_W'(WPR - 1);
                        state_reg     <= B_FILL;
                    end
                    else if (!q_empty)
                    begin
                        walk_addr_reg  <= q_job.addr;
                        bitpos_reg     <= q_job.bit_pos;
                        remain_reg     <= q_job.count;
                        wr_reg         <= q_job.wr;
                        set_reg        <= q_job.set;
                        chk_reg        <= q_job.chk;
                        in_region_reg  <= q_job.in_region;
                        region_hit_reg <= q_job.region_hit;
                        overrun_reg    <= q_job.overrun;
                        acc_reg        <= 1'b0;
                        state_reg      <= B_WALK;
                    end
                end
                B_WALK:
                begin
                    if (issue)
                    begin
                        s1_addr_reg   <= walk_addr_reg;
                        s1_mask_reg   <= mask;
                        walk_addr_reg <= walk_addr_reg + 1'b1;
                        bitpos_reg    <= '0;
                        remain_reg    <= remain_reg - take;
                    end
                    else if (!s1_valid_reg)
                    begin
                        done_reg           <= 1'b1;
                        poisoned_reg       <= chk_reg && acc_reg;
                        out_in_region_reg  <= in_region_reg;
                        out_region_hit_reg <= region_hit_reg;
                        out_overrun_reg    <= overrun_reg;
                        state_reg          <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    assign done       = done_reg;
    assign poisoned   = poisoned_reg;
    assign in_region  = out_in_region_reg;
    assign region_hit = out_region_hit_reg;
    assign overrun    = out_overrun_reg;

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held for more than one cycle");

    a_done_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == B_WALK))
        else $error("result strobe without a finished walk");

    a_s1_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (state_reg == B_WALK))
        else $error("shadow word in flight outside a walk");

    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_IDLE) |-> (remain_reg == '0 && !s1_valid_reg))
        else $error("walker idle with granules left over");

endmodule

FILE: bench/shadow_bitmap_poison_tracker_unit_test.sv
// ----------------------------------------------------------------------------
// shadow_bitmap_poison_tracker_unit_test
// Self-checking bench for the shadow bitmap poison tracker. A short table of
// directed commands and register writes comes first. Phases of random
// commands follow, each under fresh region settings. A predictor keeps its own
// copy of the shadow bitmaps and registers, and each result strobe is checked
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module shadow_bitmap_poison_tracker_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    import sbpt_pkg::*;

    localparam int REGIONS       = REGIONS_DEF;
    localparam int GRANULE       = GRANULE_BYTES_DEF;
    localparam int REGION_MAX    = REGION_MAX_BYTES_DEF;
    localparam int MAX_GRANULES  = (REGION_MAX + GRANULE - 1) / GRANULE;

    // opcode the block leaves unused: reported, but no shadow change
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int RESET_CYCLES  = 11;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 112;
    // quiet spell long enough for two full-region walks in flight
    localparam int DRAIN_CYCLES  = 1200;
    // watchdog limit, several times the slowest legal run
    localparam int CYCLE_LIMIT   = 2500000;

    typedef enum logic [1:0]
    {
        REG_REGION0_BASE = 2'd0,
        REG_REGION0_SIZE = 2'd1,
        REG_REGION1_BASE = 2'd2,
        REG_REGION1_SIZE = 2'd3
    } reg_idx_e;

    typedef struct packed
    {
        logic poisoned;
        logic in_region;
        logic region_hit;
        logic overrun;
    } result_t;

    typedef enum logic
    {
        ROW_CMD = 1'b0,
        ROW_CFG = 1'b1
    } row_kind_e;

    typedef struct packed
    {
        row_kind_e          kind;
        logic [OP_W-1:0]    op;
        logic [ADDR_W-1:0]  addr;
        logic [LEN_W-1:0]   len;
        reg_idx_e           reg_idx;
        logic [DATA_W-1:0]  reg_data;
        logic               typed;      // expectation written into the row
        result_t            want;
    } plan_row_t;

    // ------------------------------------------------------------------------
    // DUT signals; every input has a known value from time zero
    // ------------------------------------------------------------------------
    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                start     = 1'b0;
    logic                busy;
    logic [OP_W-1:0]     operation = '0;
    logic [ADDR_W-1:0]   address   = '0;
    logic [LEN_W-1:0]    length    = '0;
    logic                done;
    logic                poisoned;
    logic                in_region;
    logic                region_hit;
    logic                overrun;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [1:0]          cfg_index = '0;
    logic [DATA_W-1:0]   cfg_data  = '0;

    shadow_bitmap_poison_tracker_unit i_dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .operation  (operation),
        .address    (address),
        .length     (length),
        .done       (done),
        .poisoned   (poisoned),
        .in_region  (in_region),
        .region_hit (region_hit),
        .overrun    (overrun),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Predictor state: own copy of registers and shadow bitmaps.
    // Reset value is every granule poisoned, registers zero.
    // ------------------------------------------------------------------------
    logic [ADDR_W-1:0]  region_base_q [REGIONS];
    logic [SIZE_W-1:0]  region_size_q [REGIONS];
    bit                 shadow_map    [REGIONS][MAX_GRANULES];

    result_t            pending_results [$];
    int unsigned        fail_count = 0;
    int unsigned        cycle_count = 0;
    plan_row_t          directed_plan [$];

    // sizes above the ceiling behave as the ceiling
    function automatic longint unsigned eff_size(int r);
        longint unsigned s;
        s = region_size_q[r];
        return (s > REGION_MAX) ? longint'(REGION_MAX) : s;
    endfunction

    function automatic void repoison_region(int r);
        for (int g = 0; g < MAX_GRANULES; g++)
            shadow_map[r][g] = 1'b1;
    endfunction

    function automatic void apply_reg(reg_idx_e idx, logic [DATA_W-1:0] data);
        int r;
        r = int'(idx) / 2;
        if (idx[0] == 1'b0)
        begin
            region_base_q[r] = data;
        end
        else
        begin
            // any size write, zero included, re-poisons the whole slice
            region_size_q[r] = data[SIZE_W-1:0];
            repoison_region(r);
        end
    endfunction

    // Applies one command to the shadow copy and returns its result.
    function automatic result_t track_access(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr,
                                             logic [LEN_W-1:0] len);
        result_t          res;
        int               hit;
        longint unsigned  a, b, ln, sz, off, first, lim, n;
        bit               found;
        res   = '0;
        hit   = -1;
        found = 1'b0;
        a     = addr;
        ln    = len;
        // first registered region holding the address wins
        for (int r = 0; r < REGIONS; r++)
        begin
            b = region_base_q[r];
            if (hit < 0 && eff_size(r) != 0 && a >= b && a - b < eff_size(r))
                hit = r;
        end
        if (hit < 0)
            return res;

        sz    = eff_size(hit);
        off   = a - region_base_q[hit];
        first = off / GRANULE;
        lim   = (sz + GRANULE - 1) / GRANULE;

        res.in_region  = 1'b1;
        res.region_hit = hit[0];
        res.overrun    = (off + ln > sz);

        if (op == OP_POISON || op == OP_UNPOISON)
        begin
            // partial trailing granule is dropped
            n = ln / GRANULE;
            if (n > lim - first)
                n = lim - first;
            for (longint unsigned g = first; g < first + n; g++)
                shadow_map[hit][g] = (op == OP_POISON);
        end
        else if (op == OP_CHECK)
        begin
            if (ln <= GRANULE)
            begin
                // short or empty check looks at the start granule only
                found = shadow_map[hit][first];
            end
            else
            begin
                n = (ln + GRANULE - 1) / GRANULE;
                if (n > lim - first)
                    n = lim - first;
                for (longint unsigned g = first; g < first + n; g++)
                    if (shadow_map[hit][g])
                        found = 1'b1;
            end
            res.poisoned = found;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Result monitor: the block cannot be held off, so every done cycle is a
    // transfer. Compare with the oldest prediction.
    // ------------------------------------------------------------------------
    task automatic check_field(string name, logic want, logic got);
        if (got !== want)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0b actual %0b", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                fail_count++;
                $display("%0t: result transfer with nothing expected, expected none actual %b",
                         $time, {poisoned, in_region, region_hit, overrun});
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("poisoned",   want.poisoned,   poisoned);
                check_field("in_region",  want.in_region,  in_region);
                check_field("region_hit", want.region_hit, region_hit);
                check_field("overrun",    want.overrun,    overrun);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Command and register drivers. All drive happens in the time step of a
    // rising edge; handshakes are sampled at the edge that completes them.
    // ------------------------------------------------------------------------

    // Waits gap cycles, presents the command and holds it until transferred.
    // hold keeps start high for a back-to-back follower.
    task automatic run_item(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr,
                            logic [LEN_W-1:0] len, int gap, bit hold,
                            bit typed, result_t want);
        result_t res;
        repeat (gap) @(posedge clk);
        start     <= 1'b1;
        operation <= op;
        address   <= addr;
        length    <= len;
        do
            @(posedge clk);
        while (busy);
        res = track_access(op, addr, len);
        pending_results.push_back(typed ? want : res);
        if (!hold)
            start <= 1'b0;
    endtask

    // Register writes only with the block drained; cfg_ready also waits for
    // any shadow sweep.
    task automatic write_reg(reg_idx_e idx, logic [DATA_W-1:0] data);
        while (pending_results.size() != 0)
            @(posedge clk);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        apply_reg(idx, data);
    endtask

    // ------------------------------------------------------------------------
    // Random stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [SIZE_W-1:0] draw_size();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0:       return '0;
            1:       return SIZE_W'(REGION_MAX);
            2:       return SIZE_W'($urandom_range(REGION_MAX + 1, (1 << SIZE_W) - 1));
            default: return SIZE_W'($urandom_range(1, 1024));
        endcase
    endfunction

    // New settings for both regions: plain, near the top of the address
    // space, overlapping, disabled and oversized all turn up.
    task automatic set_regions();
        logic [ADDR_W-1:0] base_val [REGIONS];
        logic [SIZE_W-1:0] size_val [REGIONS];
        int                sel;
        for (int r = 0; r < REGIONS; r++)
        begin
            size_val[r] = draw_size();
            sel = $urandom_range(0, 9);
            if (sel == 0)
                base_val[r] = '0;
            else if (sel == 1)
                base_val[r] = 32'hFFFF_FFFF - ADDR_W'($urandom_range(0, 1023));
            else if (sel == 2 && r > 0)
                base_val[r] = base_val[0] + ADDR_W'($urandom_range(0, 255));
            else
                base_val[r] = $urandom();
        end
        if (size_val[0] == 0 && size_val[1] == 0)
            size_val[0] = SIZE_W'($urandom_range(1, 256));
        for (int r = 0; r < REGIONS; r++)
        begin
            write_reg(reg_idx_e'(2 * r), base_val[r]);
            // upper data bits beyond the size field are junk now and then
            if ($urandom_range(0, 3) == 0)
                write_reg(reg_idx_e'(2 * r + 1),
                          {(DATA_W - SIZE_W)'($urandom()), size_val[r]});
            else
                write_reg(reg_idx_e'(2 * r + 1), DATA_W'(size_val[r]));
        end
    endtask

    // Mostly commands inside a live region (some close to its end, some just
    // outside it), the rest noise across the whole address space.
    task automatic pick_item(output logic [OP_W-1:0] op, output logic [ADDR_W-1:0] addr,
                             output logic [LEN_W-1:0] len);
        int               live [$];
        int               sel, lsel, r;
        longint unsigned  sz, off;
        for (int i = 0; i < REGIONS; i++)
            if (eff_size(i) != 0)
                live.push_back(i);
        sel  = $urandom_range(0, 99);
        lsel = $urandom_range(0, 99);
        op   = ($urandom_range(0, 15) == 0) ? OP_UNUSED : OP_W'($urandom_range(0, 2));
        if (lsel < 70)
            len = LEN_W'($urandom_range(0, 48));
        else if (lsel < 95)
            len = LEN_W'($urandom_range(0, 600));
        else
            len = LEN_W'($urandom_range(0, REGION_MAX));

        if (live.size() == 0 || sel >= 90)
        begin
            addr = $urandom();
            op   = OP_W'($urandom_range(0, 3));
            len  = LEN_W'($urandom_range(0, REGION_MAX));
        end
        else
        begin
            r  = live[$urandom_range(0, live.size() - 1)];
            sz = eff_size(r);
            if (sel < 60)
                off = $urandom_range(0, int'(sz - 1));
            else if (sel < 80 && sz > 16)
                off = sz - 1 - $urandom_range(0, 15);
            else if (sel < 80)
                off = $urandom_range(0, int'(sz - 1));
            else if (sel < 85)
                off = -longint'($urandom_range(1, 8));   // just below the base
            else
                off = sz + $urandom_range(0, 7);          // at or past the end
            addr = ADDR_W'(region_base_q[r] + off);
        end
    endtask

    // ------------------------------------------------------------------------
    // Directed table. Typed expectations where they are plain; the rest goes
    // through the predictor. Result bits: poisoned, in_region, hit, overrun.
    // ------------------------------------------------------------------------
    function automatic plan_row_t cmd_row(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr,
                                          logic [LEN_W-1:0] len, bit typed, logic [3:0] want);
        plan_row_t row;
        row         = '0;
        row.kind    = ROW_CMD;
        row.op      = op;
        row.addr    = addr;
        row.len     = len;
        row.typed   = typed;
        row.want    = result_t'(want);
        return row;
    endfunction

    function automatic plan_row_t cfg_row(reg_idx_e idx, logic [DATA_W-1:0] data);
        plan_row_t row;
        row          = '0;
        row.kind     = ROW_CFG;
        row.reg_idx  = idx;
        row.reg_data = data;
        return row;
    endfunction

    initial
    begin
        // registers cleared, no region live: everything misses
        directed_plan.push_back(cmd_row(OP_CHECK,    32'h0000_0000, 17'd0,     1, 4'b0000));
        directed_plan.push_back(cmd_row(OP_POISON,   32'hFFFF_FFFF, 17'd65536, 1, 4'b0000));
        // region 0 small and low, region 1 full size up to the top address
        directed_plan.push_back(cfg_row(REG_REGION0_BASE, 32'h0000_1000));
        directed_plan.push_back(cfg_row(REG_REGION0_SIZE, 32'd64));
        directed_plan.push_back(cfg_row(REG_REGION1_BASE, 32'hFFFF_0000));
        directed_plan.push_back(cfg_row(REG_REGION1_SIZE, 32'd65536));
        // fresh size write leaves every granule poisoned
        directed_plan.push_back(cmd_row(OP_CHECK,    32'h0000_1000, 17'd4,     1, 4'b1100));
        directed_plan.push_back(cmd_row(OP_UNPOISON, 32'h0000_1000, 17'd64,    1, 4'b0100));
        directed_plan.push_back(cmd_row(OP_CHECK,    32'h0000_1000, 17'd64,    1, 4'b0100));
        // crosses the region end: clipped and flagged
        directed_plan.push_back(cmd_row(OP_CHECK,    32'h0000_1000, 17'd65,    1, 4'b0101));
        // less than a granule poisons nothing
        directed_plan.push_back(cmd_row(OP_POISON,   32'h0000_1003, 17'd3,     0, 4'b0000));
        directed_plan.push_back(cmd_row(OP_CHECK,    32'h0000_1000, 17'd0,     0, 4'b0000));
        // unaligned start, two whole granules
        directed_plan.push_back(cmd_row(OP_POISON,   32'h0000_1005, 17'd8,     0, 4'b0000));
        directed_plan.push_back(cmd_row(OP_CHECK,    32'h0000_1000, 17'd4,     0, 4'b0000));
        directed_plan.push_back(cmd_row(OP_CHECK,    32'h0000_1004, 17'd1,     0, 4'b0000));
        directed_plan.push_back(cmd_row(OP_CHECK,    32'h0000_103C, 17'd100,   0, 4'b0000));
        // one byte either side of region 0
        directed_plan.push_back(cmd_row(OP_POISON,   32'h0000_0FFF, 17'd8,     1, 4'b0000));
        directed_plan.push_back(cmd_row(OP_CHECK,    32'h0000_1040, 17'd4,     1, 4'b0000));
        // unused opcode still reports the region
        directed_plan.push_back(cmd_row(OP_UNUSED,   32'h0000_1004, 17'd8,     1, 4'b0100));
        // last byte of the address space, a full-region length
        directed_plan.push_back(cmd_row(OP_CHECK,    32'hFFFF_FFFF, 17'd65536, 1, 4'b1111));
        directed_plan.push_back(cmd_row(OP_UNPOISON, 32'hFFFF_0000, 17'd65536, 1, 4'b0110));
        directed_plan.push_back(cmd_row(OP_CHECK,    32'hFFFF_0000, 17'd65536, 1, 4'b0110));
        // oversized size with junk upper bits: treated as the ceiling, re-poisoned
        directed_plan.push_back(cfg_row(REG_REGION1_SIZE, 32'hFFFF_FFFF));
        directed_plan.push_back(cmd_row(OP_CHECK,    32'hFFFF_FFFC, 17'd4,     1, 4'b1110));
        // base move keeps region 0 shadow; overlap goes to region 0 first
        directed_plan.push_back(cfg_row(REG_REGION0_BASE, 32'hFFFF_8000));
        directed_plan.push_back(cmd_row(OP_CHECK,    32'hFFFF_8000, 17'd8,     0, 4'b0000));
        directed_plan.push_back(cmd_row(OP_CHECK,    32'hFFFF_8040, 17'd4,     0, 4'b0000));
        // size zero retires region 0; region 1 takes over
        directed_plan.push_back(cfg_row(REG_REGION0_SIZE, 32'd0));
        directed_plan.push_back(cmd_row(OP_CHECK,    32'hFFFF_8000, 17'd4,     0, 4'b0000));
        directed_plan.push_back(cmd_row(OP_POISON,   32'hFFFF_FFF0, 17'd5,     0, 4'b0000));
        directed_plan.push_back(cmd_row(OP_UNPOISON, 32'h0000_0000, 17'd0,     1, 4'b0000));
    end

    // ------------------------------------------------------------------------
    // Run watchdog
    // ------------------------------------------------------------------------
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  len;
        int                gap, next_gap;
        bit                hold, pause, next_pause, burst;

        for (int r = 0; r < REGIONS; r++)
        begin
            region_base_q[r] = '0;
            region_size_q[r] = '0;
            repoison_region(r);
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // directed table; the row after a command decides whether start stays up
        next_gap = $urandom_range(0, 19);
        for (int i = 0; i < directed_plan.size(); i++)
        begin
            gap      = next_gap;
            next_gap = $urandom_range(0, 19);
            if (directed_plan[i].kind == ROW_CFG)
            begin
                write_reg(directed_plan[i].reg_idx, directed_plan[i].reg_data);
            end
            else
            begin
                hold = (i + 1 < directed_plan.size()) && next_gap == 0 &&
                       directed_plan[i + 1].kind == ROW_CMD;
                run_item(directed_plan[i].op, directed_plan[i].addr, directed_plan[i].len,
                         gap, hold, directed_plan[i].typed, directed_plan[i].want);
            end
        end

        // random phases; bursts with no gaps come and go, and halfway through
        // each phase the sender holds off until the block has drained
        burst = 1'b0;
        for (int p = 0; p < PHASES; p++)
        begin
            set_regions();
            next_gap   = $urandom_range(0, 19);
            next_pause = 1'b0;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                gap   = next_gap;
                pause = next_pause;
                if ($urandom_range(0, 31) == 0)
                    burst = !burst;
                next_gap   = burst ? 0 : $urandom_range(0, 19);
                next_pause = (i + 1 == PHASE_ITEMS / 2);
                hold       = (i + 1 < PHASE_ITEMS) && next_gap == 0 && !next_pause;
                if (pause)
                begin
                    while (pending_results.size() != 0)
                        @(posedge clk);
                    @(posedge clk);
                end
                pick_item(op, addr, len);
                run_item(op, addr, len, gap, hold, 1'b0, result_t'(4'b0000));
            end
        end

        // drain, then a quiet spell to catch stray strobes
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
